// ----- src/drag_polar_fit_defines.svh -----
// assertion macros for the drag polar fit block
`ifndef DRAG_POLAR_FIT_DEFINES_SVH
`define DRAG_POLAR_FIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dpf_pkg.sv -----
// shared types, constants and decode function of the drag polar fit block
`default_nettype none

package dpf_pkg;

    localparam int DEF_MAX_POINTS   = 256;
    localparam int DEF_IN_FRAC_BITS = 12;

    localparam int COEF_W  = 16;
    localparam int C0_W    = 20;
    localparam int K_W     = 20;
    localparam int SUM_W   = 64;
    localparam int HALF_W  = 32;
    localparam int WIDE_W  = 128;

    localparam int MIN_FIT_POINTS = 3;
    localparam int C0_POS_MAX     = 524287;
    localparam int C0_NEG_MAG     = 524288;
    localparam int K_MAX          = 1048575;

    localparam int PROD_W    = 3;
    localparam int PART_W    = 2;
    localparam int STEP_W    = PROD_W + PART_W;
    localparam int MUL_STEPS = 24;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_CD0,
        DIV_KF
    } div_mode_t;

    typedef enum logic [1:0] {
        ACC_DET,
        ACC_NC,
        ACC_NK
    } acc_dest_t;

    typedef enum logic [2:0] {
        OPND_N,
        OPND_SX,
        OPND_SXX,
        OPND_SY,
        OPND_SXY
    } opnd_t;

    typedef struct packed {
        opnd_t     a;
        opnd_t     b;
        acc_dest_t dest;
        logic      sub;
    } prod_t;

    typedef struct packed {
        logic                take;
        logic                fit_clear;
        logic                mul_valid;
        logic [PROD_W-1:0]   mul_prod;
        logic [PART_W-1:0]   mul_part;
        logic                div_start;
        div_mode_t           div_mode;
        logic                load_out;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic too_few;
        logic det_zero;
        logic div_done;
        logic out_busy;
    } stat_t;

    // det = n*Sxx - Sx*Sx, nc = Sxx*Sy - Sx*Sxy, nk = n*Sxy - Sx*Sy
    function automatic prod_t prod_info(input logic [PROD_W-1:0] idx);
        prod_t p;
        p.a    = OPND_N;
        p.b    = OPND_SXX;
        p.dest = ACC_DET;
        p.sub  = 1'b0;
        unique case (idx)
            3'd0:
            begin
                p.a = OPND_N;   p.b = OPND_SXX; p.dest = ACC_DET; p.sub = 1'b0;
            end
            3'd1:
            begin
                p.a = OPND_SX;  p.b = OPND_SX;  p.dest = ACC_DET; p.sub = 1'b1;
            end
            3'd2:
            begin
                p.a = OPND_SXX; p.b = OPND_SY;  p.dest = ACC_NC;  p.sub = 1'b0;
            end
            3'd3:
            begin
                p.a = OPND_SX;  p.b = OPND_SXY; p.dest = ACC_NC;  p.sub = 1'b1;
            end
            3'd4:
            begin
                p.a = OPND_N;   p.b = OPND_SXY; p.dest = ACC_NK;  p.sub = 1'b0;
            end
            3'd5:
            begin
                p.a = OPND_SX;  p.b = OPND_SY;  p.dest = ACC_NK;  p.sub = 1'b1;
            end
            default:
            begin
                p.sub = 1'b0;
            end
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- src/drag_polar_fit.sv -----
// points are taken one beat per cycle; after the last beat the block takes no beat while it
// drains the accumulation pipeline, forms the six 64x64 products on one shared 32x32 multiplier
// and runs two passes of the bit-serial divider (one pass when the determinant is zero, none
// with fewer than three points used)
// rst_n clears the run sums, the extremes and the output beat at once
`default_nettype none

module drag_polar_fit #(
    parameter int MAX_POINTS   = dpf_pkg::DEF_MAX_POINTS,
    parameter int IN_FRAC_BITS = dpf_pkg::DEF_IN_FRAC_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // lift_coef, drag_coef, moment_coef
    input  wire logic        s_tlast,   // is_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // zero_lift_drag, induced_factor, lift_max,
                                        // lift_min, moment_at_min_lift
    output logic             m_tuser    // fit_status
);
    import dpf_pkg::*;

    cmd_t                     cmd;
    stat_t                    stat;
    logic signed [C0_W-1:0]   zero_lift_drag;
    logic [K_W-1:0]           induced_factor;
    logic signed [COEF_W-1:0] lift_max, lift_min, moment_at_min_lift;

    dpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dpf_datapath #(
        .MAX_POINTS   (MAX_POINTS),
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .lift_coef          (s_tdata[15:0]),
        .drag_coef          (s_tdata[31:16]),
        .moment_coef        (s_tdata[47:32]),
        .out_ready          (m_tready),
        .out_valid          (m_tvalid),
        .zero_lift_drag     (zero_lift_drag),
        .induced_factor     (induced_factor),
        .lift_max           (lift_max),
        .lift_min           (lift_min),
        .moment_at_min_lift (moment_at_min_lift),
        .fit_status         (m_tuser)
    );

    assign m_tdata = {moment_at_min_lift, lift_min, lift_max, induced_factor, zero_lift_drag};

endmodule

`default_nettype wire

// ----- src/dpf_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module dpf_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [dpf_pkg::WIDE_W-1:0] num,
    input  wire logic [dpf_pkg::WIDE_W-1:0] den,
    output logic                           done,
    output logic [dpf_pkg::WIDE_W-1:0]     quo
);
    import dpf_pkg::*;

    localparam int CNT_W = $clog2(WIDE_W);

    logic [WIDE_W-1:0] rem_reg, rem_next;
    logic [WIDE_W-1:0] nq_reg, nq_next;
    logic [WIDE_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WIDE_W:0]   trial;
    logic [WIDE_W:0]   diff;
    logic              ge;

    always_comb
    begin
        trial    = {rem_reg, nq_reg[WIDE_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = ~diff[WIDE_W];
        rem_next = ge ? diff[WIDE_W-1:0] : trial[WIDE_W-1:0];
        nq_next  = {nq_reg[WIDE_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WIDE_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            nq_reg  <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
        end
    end

    assign done = done_reg;
    assign quo  = nq_reg;

endmodule

`default_nettype wire

// ----- src/dpf_datapath.sv -----
// accumulation pipeline, wide product unit, divider and result registers
`default_nettype none

module dpf_datapath #(
    parameter int MAX_POINTS   = dpf_pkg::DEF_MAX_POINTS,
    parameter int IN_FRAC_BITS = dpf_pkg::DEF_IN_FRAC_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dpf_pkg::cmd_t                     cmd,
    output dpf_pkg::stat_t                         stat,
    input  wire logic signed [dpf_pkg::COEF_W-1:0] lift_coef,
    input  wire logic        [dpf_pkg::COEF_W-1:0] drag_coef,
    input  wire logic signed [dpf_pkg::COEF_W-1:0] moment_coef,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic signed [dpf_pkg::C0_W-1:0]        zero_lift_drag,
    output logic        [dpf_pkg::K_W-1:0]         induced_factor,
    output logic signed [dpf_pkg::COEF_W-1:0]      lift_max,
    output logic signed [dpf_pkg::COEF_W-1:0]      lift_min,
    output logic signed [dpf_pkg::COEF_W-1:0]      moment_at_min_lift,
    output logic                                   fit_status
);
    import dpf_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int MAG_W = IN_FRAC_BITS + 1;
    localparam int X_W   = 2 * MAG_W;
    localparam int XX_W  = 2 * X_W;
    localparam int DX_W  = COEF_W + X_W;
    localparam int UNIT  = 1 << IN_FRAC_BITS;
    localparam int KSH   = 2 * IN_FRAC_BITS;

    // run state
    logic [CNT_W-1:0]         cnt_reg;
    logic [SUM_W-1:0]         sum_x_reg, sum_xx_reg, sum_y_reg, sum_xy_reg;
    logic signed [COEF_W-1:0] lift_high_reg, lift_low_reg, best_moment_reg;
    logic [COEF_W-1:0]        best_abs_reg;

    // accumulation pipeline
    logic              v1_reg, v2_reg, v3_reg;
    logic [MAG_W-1:0]  mag1_reg;
    logic [COEF_W-1:0] drag1_reg, drag2_reg, drag3_reg;
    logic [X_W-1:0]    x2_reg, x3_reg;
    logic [XX_W-1:0]   xx3_reg;
    logic [DX_W-1:0]   dx3_reg;

    logic [COEF_W-1:0] mag;
    logic              use_pt;

    // wide products
    prod_t             pinfo;
    logic [SUM_W-1:0]  a_op, b_op;
    logic [HALF_W-1:0] a_half, b_half;
    logic [SUM_W-1:0]  pp_reg;
    logic              pp_v_reg;
    acc_dest_t         pp_dest_reg;
    logic              pp_sub_reg;
    logic              pp_clr_reg;
    logic [1:0]        pp_sh_reg;
    logic [WIDE_W-1:0] term, acc_base, acc_new;
    logic [WIDE_W-1:0] det_reg, nc_reg, nk_reg;

    // division
    logic [WIDE_W-1:0] num_s, den_s, num_mag, den_mag, div_num, div_den;
    logic              div_neg;
    logic              div_neg_reg;
    div_mode_t         div_mode_reg;
    logic              div_done;
    logic [WIDE_W-1:0] quo;
    logic [C0_W-1:0]   c0_mag;

    // fit and output registers
    logic signed [C0_W-1:0]   c0_reg;
    logic [K_W-1:0]           k_reg;
    logic                     out_valid_reg;
    logic signed [C0_W-1:0]   out_c0_reg;
    logic [K_W-1:0]           out_k_reg;
    logic signed [COEF_W-1:0] out_lmax_reg, out_lmin_reg, out_mom_reg;
    logic                     out_status_reg;

    assign mag    = lift_coef[COEF_W-1] ? COEF_W'(-lift_coef) : lift_coef;
    assign use_pt = (mag <= COEF_W'(UNIT)) && (cnt_reg < CNT_W'(MAX_POINTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            sum_x_reg       <= '0;
            sum_xx_reg      <= '0;
            sum_y_reg       <= '0;
            sum_xy_reg      <= '0;
            lift_high_reg   <= {1'b1, {(COEF_W-1){1'b0}}};
            lift_low_reg    <= {1'b0, {(COEF_W-1){1'b1}}};
            best_abs_reg    <= '1;
            best_moment_reg <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            cnt_reg         <= '0;
            sum_x_reg       <= '0;
            sum_xx_reg      <= '0;
            sum_y_reg       <= '0;
            sum_xy_reg      <= '0;
            lift_high_reg   <= {1'b1, {(COEF_W-1){1'b0}}};
            lift_low_reg    <= {1'b0, {(COEF_W-1){1'b1}}};
            best_abs_reg    <= '1;
            best_moment_reg <= '0;
        end
        else
        begin
            v1_reg <= cmd.take && use_pt;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.take)
            begin
                if (use_pt)
                    cnt_reg <= cnt_reg + CNT_W'(1);
                if (lift_coef > lift_high_reg)
                    lift_high_reg <= lift_coef;
                if (lift_coef < lift_low_reg)
                    lift_low_reg <= lift_coef;
                if (mag < best_abs_reg)
                begin
                    best_abs_reg    <= mag;
                    best_moment_reg <= moment_coef;
                end
            end
            if (v3_reg)
            begin
                sum_x_reg  <= sum_x_reg + SUM_W'(x3_reg);
                sum_xx_reg <= sum_xx_reg + SUM_W'(xx3_reg);
                sum_y_reg  <= sum_y_reg + SUM_W'(drag3_reg);
                sum_xy_reg <= sum_xy_reg + SUM_W'(dx3_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag1_reg  <= mag[MAG_W-1:0];
        drag1_reg <= drag_coef;
        x2_reg    <= X_W'(mag1_reg) * X_W'(mag1_reg);
        drag2_reg <= drag1_reg;
        xx3_reg   <= XX_W'(x2_reg) * XX_W'(x2_reg);
        dx3_reg   <= DX_W'(drag2_reg) * DX_W'(x2_reg);
        x3_reg    <= x2_reg;
        drag3_reg <= drag2_reg;
    end

    always_comb
    begin
        pinfo = prod_info(cmd.mul_prod);
        case (pinfo.a)
            OPND_N:   a_op = SUM_W'(cnt_reg);
            OPND_SX:  a_op = sum_x_reg;
            OPND_SXX: a_op = sum_xx_reg;
            OPND_SY:  a_op = sum_y_reg;
            OPND_SXY: a_op = sum_xy_reg;
            default:  a_op = '0;
        endcase
        case (pinfo.b)
            OPND_N:   b_op = SUM_W'(cnt_reg);
            OPND_SX:  b_op = sum_x_reg;
            OPND_SXX: b_op = sum_xx_reg;
            OPND_SY:  b_op = sum_y_reg;
            OPND_SXY: b_op = sum_xy_reg;
            default:  b_op = '0;
        endcase
        a_half = cmd.mul_part[1] ? a_op[SUM_W-1:HALF_W] : a_op[HALF_W-1:0];
        b_half = cmd.mul_part[0] ? b_op[SUM_W-1:HALF_W] : b_op[HALF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pp_v_reg <= 1'b0;
        else
            pp_v_reg <= cmd.mul_valid;
    end

    always_ff @(posedge clk)
    begin
        pp_reg      <= SUM_W'(a_half) * SUM_W'(b_half);
        pp_dest_reg <= pinfo.dest;
        pp_sub_reg  <= pinfo.sub;
        pp_clr_reg  <= !pinfo.sub && (cmd.mul_part == '0);
        pp_sh_reg   <= 2'(cmd.mul_part[1]) + 2'(cmd.mul_part[0]);
    end

    // partial product placed at 0, 32 or 64 bits
    always_comb
    begin
        term = WIDE_W'(pp_reg) << {pp_sh_reg, 5'd0};
        case (pp_dest_reg)
            ACC_DET: acc_base = det_reg;
            ACC_NC:  acc_base = nc_reg;
            ACC_NK:  acc_base = nk_reg;
            default: acc_base = '0;
        endcase
        if (pp_clr_reg)
            acc_base = '0;
        acc_new = pp_sub_reg ? (acc_base - term) : (acc_base + term);
    end

    always_ff @(posedge clk)
    begin
        if (pp_v_reg)
        begin
            case (pp_dest_reg)
                ACC_DET: det_reg <= acc_new;
                ACC_NC:  nc_reg  <= acc_new;
                ACC_NK:  nk_reg  <= acc_new;
                default: det_reg <= det_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.div_mode)
            DIV_CD0: num_s = nc_reg;
            DIV_KF:  num_s = nk_reg << KSH;
            default: num_s = WIDE_W'(sum_y_reg);
        endcase
        den_s   = (cmd.div_mode == DIV_MEAN) ? WIDE_W'(cnt_reg) : det_reg;
        num_mag = num_s[WIDE_W-1] ? (~num_s + WIDE_W'(1)) : num_s;
        den_mag = den_s[WIDE_W-1] ? (~den_s + WIDE_W'(1)) : den_s;
        div_neg = num_s[WIDE_W-1] ^ den_s[WIDE_W-1];
        div_num = (cmd.div_mode == DIV_MEAN) ? num_s : num_mag;
        div_den = (cmd.div_mode == DIV_MEAN) ? den_s : den_mag;
    end

    dpf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    assign c0_mag = (quo > WIDE_W'(C0_NEG_MAG)) ? C0_W'(C0_NEG_MAG) : quo[C0_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_neg_reg  <= (cmd.div_mode == DIV_MEAN) ? 1'b0 : div_neg;
            div_mode_reg <= cmd.div_mode;
        end
        if (cmd.fit_clear)
        begin
            c0_reg <= '0;
            k_reg  <= '0;
        end
        else if (div_done)
        begin
            case (div_mode_reg)
                DIV_KF:
                begin
                    if (div_neg_reg)
                        k_reg <= '0;
                    else if (quo > WIDE_W'(K_MAX))
                        k_reg <= K_W'(K_MAX);
                    else
                        k_reg <= quo[K_W-1:0];
                end
                default:
                begin
                    if (div_neg_reg)
                        c0_reg <= ~c0_mag + C0_W'(1);
                    else if (quo > WIDE_W'(C0_POS_MAX))
                        c0_reg <= C0_W'(C0_POS_MAX);
                    else
                        c0_reg <= quo[C0_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_c0_reg     <= c0_reg;
            out_k_reg      <= k_reg;
            out_lmax_reg   <= lift_high_reg;
            out_lmin_reg   <= lift_low_reg;
            out_mom_reg    <= best_moment_reg;
            out_status_reg <= stat.too_few;
        end
    end

    always_comb
    begin
        stat.pipe_busy = v1_reg | v2_reg | v3_reg | pp_v_reg;
        stat.too_few   = cnt_reg < CNT_W'(MIN_FIT_POINTS);
        stat.det_zero  = (det_reg == '0);
        stat.div_done  = div_done;
        stat.out_busy  = out_valid_reg;
    end

    assign out_valid          = out_valid_reg;
    assign zero_lift_drag     = out_c0_reg;
    assign induced_factor     = out_k_reg;
    assign lift_max           = out_lmax_reg;
    assign lift_min           = out_lmin_reg;
    assign moment_at_min_lift = out_mom_reg;
    assign fit_status         = out_status_reg;

endmodule

`default_nettype wire

// ----- src/dpf_ctrl.sv -----
// sequencing state machine: accumulate, drain, products, divisions, result
`default_nettype none

module dpf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    input  wire logic           s_tlast,
    output logic                s_tready,
    input  wire dpf_pkg::stat_t stat,
    output dpf_pkg::cmd_t       cmd
);
    import dpf_pkg::*;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_MUL,
        ST_MUL_WAIT,
        ST_DET_CHK,
        ST_DIV_C0,
        ST_DIV_K,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        s_tready      = 1'b0;
        cmd.take      = 1'b0;
        cmd.fit_clear = 1'b0;
        cmd.mul_valid = 1'b0;
        cmd.mul_prod  = step_reg[STEP_W-1:PART_W];
        cmd.mul_part  = step_reg[PART_W-1:0];
        cmd.div_start = 1'b0;
        cmd.div_mode  = DIV_MEAN;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && s_tlast)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.fit_clear = 1'b1;
                    step_next     = '0;
                    state_next    = stat.too_few ? ST_FINISH : ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_valid = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                    state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                state_next = ST_DET_CHK;
            end
            ST_DET_CHK:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = stat.det_zero ? DIV_MEAN : DIV_CD0;
                state_next    = ST_DIV_C0;
            end
            ST_DIV_C0:
            begin
                if (stat.div_done)
                begin
                    if (stat.det_zero)
                        state_next = ST_FINISH;
                    else
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_mode  = DIV_KF;
                        state_next    = ST_DIV_K;
                    end
                end
            end
            ST_DIV_K:
            begin
                if (stat.div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/dpf_checker.sv -----
// port-level checks of the drag polar fit block and their bind
`default_nettype none

`include "drag_polar_fit_defines.svh"

module dpf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata,
    input wire logic        m_tuser
);

    `DPF_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    `DPF_ASSERT_NXT(a_last_stops_input, s_tvalid && s_tready && s_tlast, !s_tready, "beat taken right after the last beat of a run")

    `DPF_ASSERT_IMP(a_too_few_zero_fit, m_tvalid && m_tuser, m_tdata[39:0] == 40'd0, "fit fields not zero with too few points")

    `DPF_ASSERT_IMP(a_lift_order, m_tvalid, $signed(m_tdata[55:40]) >= $signed(m_tdata[71:56]), "lift maximum below lift minimum")

endmodule

bind drag_polar_fit dpf_checker u_dpf_checker (.*);

`default_nettype wire
